[src/fps_pkg.sv]
package fps_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int ANGLE_W   = 32;
  localparam int OUT_W     = 19;
  localparam int ANG_BITS  = (WORD_BITS < ANGLE_W) ? WORD_BITS : ANGLE_W;

  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_C       =
    (PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
  localparam logic [63:0] TWO_PI_C   =
    ((PI_Q60 << 1) + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
  localparam logic [63:0] HALF_PI_C  =
    (PI_Q60 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);

  localparam int RED_W = $clog2(TWO_PI_C) + 2;
  localparam int X_W   = RED_W - 2;
  localparam int Y_W   = $clog2(HALF_PI_C) + 2;
  localparam int POLY_W = FRAC_BITS + 4;

  localparam int MOD_SHIFT = ANGLE_W + 12;
  localparam logic [63:0] MOD_RECIP = ((64'd1 << MOD_SHIFT) / TWO_PI_C) + 64'd1;
  localparam int RECIP_W = $clog2(MOD_RECIP) + 1;
  localparam int PROD_W  = ANGLE_W + RECIP_W;
  localparam int Q_W     = PROD_W - MOD_SHIFT;

  localparam int ONE_C = 1 << FRAC_BITS;
  localparam int S1_C  = -((ONE_C + 3) / 6);
  localparam int S2_C  = (ONE_C + 60) / 120;
  localparam int C1_C  = -((ONE_C + 1) / 2);
  localparam int C2_C  = (ONE_C + 12) / 24;

  typedef struct packed {
    logic signed [Y_W-1:0] y;
    logic                  neg;
  } fps_fold_t;

endpackage

[src/fps_if.sv]
interface fps_angle_if import fps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
  modport mon (input valid, input angle, input ready);
endinterface

interface fps_trig_if import fps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] sine;
  logic signed [OUT_W-1:0] cosine;

  modport source (output valid, output sine, output cosine, input ready);
  modport sink (input valid, input sine, input cosine, output ready);
  modport mon (input valid, input sine, input cosine, input ready);
endinterface

[src/fps_reduce.sv]
module fps_reduce import fps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fps_angle_if.sink  operand,
  output logic       fold_valid,
  input  logic       fold_ready,
  output fps_fold_t  fold
);

  localparam int Depth = 4;

  localparam logic signed [RECIP_W-1:0] RecipS  = RECIP_W'(MOD_RECIP);
  localparam logic signed [RED_W-1:0]   TwoPiS  = RED_W'(TWO_PI_C);
  localparam logic signed [RED_W-1:0]   PiS     = RED_W'(PI_C);
  localparam logic signed [RED_W-1:0]   HalfPiS = RED_W'(HALF_PI_C);

  logic [Depth-1:0] vld;
  logic [Depth-1:0] en;

  logic signed [ANGLE_W-1:0]     a_in;
  logic signed [PROD_W-1:0]      prod_in;
  logic signed [ANGLE_W-1:0]     a0;
  logic signed [PROD_W-1:0]      prod0;

  logic signed [Q_W-1:0]         quo;
  logic signed [Q_W+RED_W-1:0]   qt;
  logic signed [Q_W+RED_W-1:0]   diff;
  logic signed [RED_W-1:0]       rem1;

  logic signed [RED_W-1:0]       corr;
  logic [X_W-1:0]                x2r;

  logic signed [RED_W-1:0]       xs;
  logic signed [RED_W-1:0]       y_full;
  logic                          neg_next;
  fps_fold_t                     fold3;

  always_comb begin
    en[Depth-1] = !vld[Depth-1] || fold_ready;
    for (int i = Depth - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign operand.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= operand.valid;
      end
      for (int i = 1; i < Depth; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign a_in    = ANGLE_W'(signed'(operand.angle[ANG_BITS-1:0]));
  assign prod_in = a_in * RecipS;

  assign quo  = prod0[PROD_W-1:MOD_SHIFT];
  assign qt   = quo * TwoPiS;
  assign diff = (Q_W + RED_W)'(a0) - qt;

  always_comb begin
    if (rem1 < 0) begin
      corr = rem1 + TwoPiS;
    end else if (rem1 >= TwoPiS) begin
      corr = rem1 - TwoPiS;
    end else begin
      corr = rem1;
    end
  end

  always_comb begin
    xs = signed'(RED_W'(x2r));
    if (xs <= HalfPiS) begin
      y_full   = xs;
      neg_next = 1'b0;
    end else if (xs <= PiS) begin
      y_full   = PiS - xs;
      neg_next = 1'b1;
    end else if (xs < TwoPiS - HalfPiS) begin
      y_full   = TwoPiS - PiS - xs;
      neg_next = 1'b1;
    end else begin
      y_full   = xs - TwoPiS;
      neg_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a0    <= a_in;
      prod0 <= prod_in;
    end
    if (en[1]) begin
      rem1 <= diff[RED_W-1:0];
    end
    if (en[2]) begin
      x2r <= corr[X_W-1:0];
    end
    if (en[3]) begin
      fold3.y   <= y_full[Y_W-1:0];
      fold3.neg <= neg_next;
    end
  end

  assign fold_valid = vld[Depth-1];
  assign fold       = fold3;

endmodule

[src/fps_poly.sv]
module fps_poly import fps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        fold_valid,
  output logic        fold_ready,
  input  fps_fold_t   fold,
  fps_trig_if.source  result
);

  localparam int Depth = 4;

  localparam logic signed [POLY_W-1:0] OneP = POLY_W'(ONE_C);
  localparam logic signed [POLY_W-1:0] S1P  = POLY_W'(S1_C);
  localparam logic signed [POLY_W-1:0] S2P  = POLY_W'(S2_C);
  localparam logic signed [POLY_W-1:0] C1P  = POLY_W'(C1_C);
  localparam logic signed [POLY_W-1:0] C2P  = POLY_W'(C2_C);

  logic [Depth-1:0] vld;
  logic [Depth-1:0] en;

  logic signed [2*Y_W-1:0]      sq;
  logic signed [Y_W-1:0]        y0;
  logic                         neg0;
  logic signed [POLY_W-1:0]     x2_0;

  logic signed [2*POLY_W-1:0]   ms;
  logic signed [2*POLY_W-1:0]   mc;
  logic signed [Y_W-1:0]        y1;
  logic                         neg1;
  logic signed [POLY_W-1:0]     x2_1;
  logic signed [POLY_W-1:0]     ts1;
  logic signed [POLY_W-1:0]     tc1;

  logic signed [2*POLY_W-1:0]   ns;
  logic signed [2*POLY_W-1:0]   nc;
  logic signed [POLY_W-1:0]     cm;
  logic signed [Y_W-1:0]        y2;
  logic signed [POLY_W-1:0]     sp2;
  logic signed [POLY_W-1:0]     c2;

  logic signed [POLY_W+Y_W-1:0] fs;
  logic signed [OUT_W-1:0]      sine3;
  logic signed [OUT_W-1:0]      cosine3;

  always_comb begin
    en[Depth-1] = !vld[Depth-1] || result.ready;
    for (int i = Depth - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign fold_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= fold_valid;
      end
      for (int i = 1; i < Depth; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign sq = fold.y * fold.y;
  assign ms = S2P * x2_0;
  assign mc = C2P * x2_0;
  assign ns = ts1 * x2_1;
  assign nc = tc1 * x2_1;
  assign cm = OneP + POLY_W'(nc >>> FRAC_BITS);
  assign fs = sp2 * y2;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      y0   <= fold.y;
      neg0 <= fold.neg;
      x2_0 <= POLY_W'(sq >>> FRAC_BITS);
    end
    if (en[1]) begin
      y1   <= y0;
      neg1 <= neg0;
      x2_1 <= x2_0;
      ts1  <= POLY_W'(ms >>> FRAC_BITS) + S1P;
      tc1  <= POLY_W'(mc >>> FRAC_BITS) + C1P;
    end
    if (en[2]) begin
      y2  <= y1;
      sp2 <= POLY_W'(ns >>> FRAC_BITS) + OneP;
      c2  <= neg1 ? -cm : cm;
    end
    if (en[3]) begin
      sine3   <= OUT_W'(fs >>> FRAC_BITS);
      cosine3 <= c2[OUT_W-1:0];
    end
  end

  assign result.valid  = vld[Depth-1];
  assign result.sine   = sine3;
  assign result.cosine = cosine3;

endmodule

[src/fixed_point_sine_cosine.sv]
// Channel   Role    Carries
// --------  ------  ---------------------------------------------
// operand   sink    angle: signed Q16.16 radians, 32 bits
// result    source  sine, cosine: signed Q3.16, 19 bits each
//
// One transfer per cycle in each direction while nothing stalls. The
// pipeline has eight stages: four for the modulo-2pi reduction and
// quadrant fold, four for the two polynomials.
// Reset clears the stage valid bits only.
// A stage holds while its successor is full and stalled; empty stages close
// up, so the input keeps taking transfers until every stage is full and stalled.
module fixed_point_sine_cosine import fps_pkg::*; (
  input logic        clk,
  input logic        rst,
  fps_angle_if.sink  operand,
  fps_trig_if.source result
);

  logic      fold_valid;
  logic      fold_ready;
  fps_fold_t fold;

  fps_reduce u_reduce (
    .clk        (clk),
    .rst        (rst),
    .operand    (operand),
    .fold_valid (fold_valid),
    .fold_ready (fold_ready),
    .fold       (fold)
  );

  fps_poly u_poly (
    .clk        (clk),
    .rst        (rst),
    .fold_valid (fold_valid),
    .fold_ready (fold_ready),
    .fold       (fold),
    .result     (result)
  );

endmodule

[src/fps_checker.sv]
module fps_checker import fps_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    operand_ready,
  input logic                    result_valid,
  input logic                    result_ready,
  input logic signed [OUT_W-1:0] result_sine,
  input logic signed [OUT_W-1:0] result_cosine
);

  localparam logic signed [OUT_W-1:0] OutHi = OUT_W'(2 << FRAC_BITS);
  localparam logic signed [OUT_W-1:0] OutLo = -OutHi;

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !operand_ready |-> (result_valid && !result_ready))
    else $error("input blocked while output not stalled");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> ($stable(result_sine) && $stable(result_cosine)))
    else $error("result payload changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_sine <= OutHi && result_sine >= OutLo &&
                      result_cosine <= OutHi && result_cosine >= OutLo))
    else $error("result out of range");

endmodule

bind fixed_point_sine_cosine fps_checker u_fps_checker (
  .clk           (clk),
  .rst           (rst),
  .operand_ready (operand.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .result_sine   (result.sine),
  .result_cosine (result.cosine)
);
